// ===== hw/rtl/sorted_priority_queue_top_defines.svh =====
// Assertion macros used by the priority queue port checker
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, suppressed while reset is low
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, suppressed while reset is low
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
// Types and constants of the sorted priority queue
package spq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned FILL_W  = 5;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CLR = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef struct packed {
    op_t                        operation;
    logic signed [VALUE_W-1:0]  value;
    logic        [PRIO_W-1:0]   prio;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  out_value;
    logic                       out_valid;
    logic                       dropped;
    logic        [FILL_W-1:0]   fill;
    logic                       is_empty;
    logic                       is_full;
  } out_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic        [PRIO_W-1:0]   prio;
  } entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t entry;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted row: holds an entry, shifts or captures on command
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  entry_t     prev_entry,
  input  logic       prev_behind,
  input  entry_t     next_entry,
  output entry_t     entry,
  output logic       behind
);

  entry_t entry_r;
  entry_t entry_nxt;

  // the new entry queues behind every stored entry of equal or higher priority
  assign behind = occupied && (entry_r.prio >= ctrl.entry.prio);
  assign entry  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.enq && !behind) begin
      entry_nxt = prev_behind ? ctrl.entry : prev_entry;
    end else if (ctrl.deq) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: cell row, fill count, result register
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------
//   in      | input     | in_valid / in_ready   | in_data  (in_t)
//   out     | output    | out_valid / out_ready | out_data (out_t)
//
// One operation per cycle while the result stage is not stalled: the whole row compares
// against the new priority in parallel and shifts in the same cycle, and the result
// appears in the next cycle. The result register is the only stage; in_ready stays
// high while it is empty or being drained, so a stall on out holds exactly one beat.
// rst_n is synchronous and empties the queue; no clearing pass is needed.
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_t             out_data_r;
  out_t             result;

  cell_ctrl_t       ctrl;
  entry_t           chain [CAPACITY];
  logic             behind [CAPACITY];
  logic             accept;
  logic             full;
  logic             empty;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ctrl.enq         = accept && (in_data.operation == OP_ENQ) && !full;
  assign ctrl.deq         = accept && (in_data.operation == OP_DEQ) && !empty;
  assign ctrl.entry.value = in_data.value;
  assign ctrl.entry.prio  = in_data.prio;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_entry;
    logic   prev_behind;
    entry_t next_entry;
    logic   occupied;

    assign occupied = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign prev_entry  = ctrl.entry;
      assign prev_behind = 1'b1;
    end else begin : g_body
      assign prev_entry  = chain[i-1];
      assign prev_behind = behind[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = chain[i];
    end else begin : g_mid
      assign next_entry = chain[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied),
      .prev_entry  (prev_entry),
      .prev_behind (prev_behind),
      .next_entry  (next_entry),
      .entry       (chain[i]),
      .behind      (behind[i])
    );
  end

  always_comb begin
    count_nxt        = count_r;
    result.out_value = '0;
    result.out_valid = 1'b0;
    result.dropped   = 1'b0;
    case (in_data.operation)
      OP_ENQ: begin
        if (full) begin
          result.dropped = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      OP_DEQ: begin
        if (!empty) begin
          count_nxt        = count_r - 1'b1;
          result.out_value = chain[0].value;
          result.out_valid = 1'b1;
        end
      end
      OP_CLR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    result.fill     = FILL_W'(count_nxt);
    result.is_empty = (count_nxt == '0);
    result.is_full  = (count_nxt == CNT_W'(CAPACITY));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the beat while the consumer stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level checker for the sorted priority queue, bound to the top level
`include "sorted_priority_queue_top_defines.svh"

module spq_port_checker
  import spq_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `SPQ_ASSERT_NXT(a_beat_in_gives_result, clk, rst_n, in_valid && in_ready, out_valid, "accepted beat gave no result")
  `SPQ_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_valid, in_ready, "input stalled with empty result stage")
  `SPQ_ASSERT_IMP(a_value_only_on_deq, clk, rst_n, out_valid && !out_data.out_valid, out_data.out_value == '0, "value reported without a dequeue")
  `SPQ_ASSERT_IMP(a_drop_excludes_deq, clk, rst_n, out_valid && out_data.dropped, !out_data.out_valid && out_data.is_full, "drop flagged on a non-full queue or with a dequeue")
  `SPQ_ASSERT_NXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind sorted_priority_queue_top spq_port_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
